### rtl/tick_rule_flow_imbalance_macros.svh
// Assertion macros for the tick-rule flow imbalance block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TICK_RULE_FLOW_IMBALANCE_MACROS_SVH
`define TICK_RULE_FLOW_IMBALANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRFI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/trfi_pkg.sv
// Shared types and constants for the tick-rule flow imbalance block.
// No dependencies.
`default_nettype none

package trfi_pkg;

  localparam int VOLUME_WIDTH_DEF  = 48;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int OP_WIDTH    = 2;
  localparam int PRICE_WIDTH = 64;
  localparam int SIZE_WIDTH  = 32;
  localparam int IMB_WIDTH   = 18;
  localparam int TOT_WIDTH   = 48;

  typedef logic [OP_WIDTH-1:0] op_t;

  localparam op_t OP_TRADE = 2'd0;
  localparam op_t OP_OPEN  = 2'd1;
  localparam op_t OP_CLOSE = 2'd2;

  typedef logic [1:0] dir_t;

  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_BUY  = 2'd1;
  localparam dir_t DIR_SELL = 2'd2;

endpackage

`default_nettype wire

### rtl/tick_rule_flow_imbalance.sv
// Top level of the tick-rule flow imbalance block: trade classification,
// volume accumulation and a restoring divider for the bar-close result.
// Depends on trfi_pkg and tick_rule_flow_imbalance_macros.svh.
//
// Trade, open and unused-op requests are handled in S_IDLE without a stall,
// so they can follow back to back. A close holds in_stall high after it is
// taken, through S_SUM, S_DIFF, S_CHK, S_DIV and S_DONE, with S_DIV skipped
// when the volumes are both zero or one side is zero: S_SUM forms the total,
// S_DIFF the magnitude of the difference, S_CHK checks the full-scale and
// empty cases, then the subtractor produces one quotient bit per cycle in
// S_DIV, and S_DONE loads the output register. That last state waits while
// an earlier result is still held by out_stall.
// in_stall is high for the whole close sequence.
`default_nettype none

module tick_rule_flow_imbalance #(
  parameter int VOLUME_WIDTH  = trfi_pkg::VOLUME_WIDTH_DEF,
  parameter int FRACTION_BITS = trfi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [trfi_pkg::OP_WIDTH-1:0]        in_op,
  input  wire logic signed [trfi_pkg::PRICE_WIDTH-1:0] in_price,
  input  wire logic [trfi_pkg::SIZE_WIDTH-1:0]      in_size,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [trfi_pkg::IMB_WIDTH-1:0]     out_imbalance,
  output logic [trfi_pkg::TOT_WIDTH-1:0]            out_buy_total,
  output logic [trfi_pkg::TOT_WIDTH-1:0]            out_sell_total
);
  import trfi_pkg::*;

  localparam int TW = VOLUME_WIDTH + 1;                 // total width
  localparam int QW = FRACTION_BITS + 1;                // quotient width
  localparam int CW = $clog2(FRACTION_BITS + 1);        // step counter width
  localparam logic [VOLUME_WIDTH-1:0] VOL_MAX = '1;
  localparam logic [CW-1:0] LAST_STEP = CW'(FRACTION_BITS - 1);
  localparam logic [QW-1:0] FULL_SCALE = QW'(1) << FRACTION_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic                           bar_open_r, bar_open_nxt;
  logic                           have_last_r, have_last_nxt;
  logic signed [PRICE_WIDTH-1:0]  last_price_r, last_price_nxt;
  dir_t                           last_dir_r, last_dir_nxt;
  logic [VOLUME_WIDTH-1:0]        buy_r, buy_nxt;
  logic [VOLUME_WIDTH-1:0]        sell_r, sell_nxt;
  logic [TW-1:0]                  tot_r, tot_nxt;
  logic [TW-1:0]                  rem_r, rem_nxt;
  logic                           neg_r, neg_nxt;
  logic [QW-1:0]                  q_r, q_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [IMB_WIDTH-1:0]    out_imb_r, out_imb_nxt;
  logic [TOT_WIDTH-1:0]           out_buy_r, out_buy_nxt;
  logic [TOT_WIDTH-1:0]           out_sell_r, out_sell_nxt;

  logic                           in_take;
  logic                           out_take;
  dir_t                           trade_dir;
  logic [TW-1:0]                  add_sum;
  logic [VOLUME_WIDTH-1:0]        add_sat;
  logic [VOLUME_WIDTH-1:0]        acc_sel;
  logic [VOLUME_WIDTH-1:0]        sub_a;
  logic [VOLUME_WIDTH-1:0]        sub_b;
  logic [TW:0]                    div_shift;
  logic [TW:0]                    div_diff;
  logic signed [QW:0]             q_signed;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  // Tick rule: equal price keeps the previous direction.
  always_comb begin
    trade_dir = last_dir_r;
    if (in_price > last_price_r) begin
      trade_dir = DIR_BUY;
    end else if (in_price < last_price_r) begin
      trade_dir = DIR_SELL;
    end
  end

  // Saturating accumulator shared by the buy and sell sides.
  assign acc_sel = (trade_dir == DIR_BUY) ? buy_r : sell_r;
  assign add_sum = {1'b0, acc_sel} + TW'(in_size);
  assign add_sat = add_sum[TW-1] ? VOL_MAX : add_sum[VOLUME_WIDTH-1:0];

  assign sub_a = neg_r ? sell_r : buy_r;
  assign sub_b = neg_r ? buy_r : sell_r;

  // One restoring step of the divider's subtractor.
  assign div_shift = {rem_r, 1'b0};
  assign div_diff  = div_shift - {1'b0, tot_r};

  assign q_signed = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_comb begin
    state_nxt      = state_r;
    bar_open_nxt   = bar_open_r;
    have_last_nxt  = have_last_r;
    last_price_nxt = last_price_r;
    last_dir_nxt   = last_dir_r;
    buy_nxt        = buy_r;
    sell_nxt       = sell_r;
    tot_nxt        = tot_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_take;
    out_imb_nxt    = out_imb_r;
    out_buy_nxt    = out_buy_r;
    out_sell_nxt   = out_sell_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          priority if (in_op == OP_OPEN) begin
            bar_open_nxt   = 1'b1;
            have_last_nxt  = 1'b0;
            last_price_nxt = '0;
            last_dir_nxt   = DIR_NONE;
            buy_nxt        = '0;
            sell_nxt       = '0;
          end else if (in_op == OP_TRADE) begin
            if (bar_open_r) begin
              if (have_last_r) begin
                if (trade_dir == DIR_BUY) begin
                  buy_nxt = add_sat;
                end else if (trade_dir == DIR_SELL) begin
                  sell_nxt = add_sat;
                end
                last_dir_nxt = trade_dir;
              end
              last_price_nxt = in_price;
              have_last_nxt  = 1'b1;
            end
          end else if (in_op == OP_CLOSE) begin
            bar_open_nxt = 1'b0;
            state_nxt    = S_SUM;
          end else begin
            // drop the unused op code
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUM: begin
        tot_nxt   = {1'b0, buy_r} + {1'b0, sell_r};
        neg_nxt   = (buy_r < sell_r);
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        rem_nxt   = {1'b0, sub_a - sub_b};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = '0;
        priority if (tot_r == '0) begin
          q_nxt     = '0;
          state_nxt = S_DONE;
        end else if (rem_r == tot_r) begin
          q_nxt     = FULL_SCALE;
          state_nxt = S_DONE;
        end else begin
          q_nxt     = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_diff[TW]) begin
          rem_nxt = div_diff[TW-1:0];
          q_nxt   = {q_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = div_shift[TW-1:0];
          q_nxt   = {q_r[QW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_take) begin
          out_valid_nxt = 1'b1;
          out_imb_nxt   = IMB_WIDTH'(q_signed);
          out_buy_nxt   = TOT_WIDTH'(buy_r);
          out_sell_nxt  = TOT_WIDTH'(sell_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bar_open_r   <= 1'b0;
      have_last_r  <= 1'b0;
      last_price_r <= '0;
      last_dir_r   <= DIR_NONE;
      buy_r        <= '0;
      sell_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bar_open_r   <= bar_open_nxt;
      have_last_r  <= have_last_nxt;
      last_price_r <= last_price_nxt;
      last_dir_r   <= last_dir_nxt;
      buy_r        <= buy_nxt;
      sell_r       <= sell_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tot_r      <= tot_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_imb_r  <= out_imb_nxt;
    out_buy_r  <= out_buy_nxt;
    out_sell_r <= out_sell_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_imbalance  = out_imb_r;
  assign out_buy_total  = out_buy_r;
  assign out_sell_total = out_sell_r;

`include "tick_rule_flow_imbalance_macros.svh"

  `TRFI_ASSERT_SAME(a_rem_below_total, state_r == S_DIV, rem_r < tot_r, "remainder not below total")
  `TRFI_ASSERT_SAME(a_quot_bound, state_r == S_DONE, q_r <= FULL_SCALE, "quotient above full scale")
  `TRFI_ASSERT_NEXT(a_close_ends_bar, in_take && in_op == OP_CLOSE, !bar_open_r && state_r == S_SUM, "close did not end bar")
  `TRFI_ASSERT_NEXT(a_trade_sets_ref, in_take && in_op == OP_TRADE && bar_open_r, have_last_r && last_price_r == $past(in_price), "trade did not set reference")

endmodule

`default_nettype wire
